// File: hw/rtl/vdf_pkg.sv
package vdf_pkg;

    localparam int TABLE_DEPTH_DEF   = 4096;
    localparam int KEY_AXIS_BITS_DEF = 21;

    localparam logic [25:0] SCALE_MAX = 26'd65536000;
    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;

    // 64-bit golden ratio hash constant, split in halves
    localparam logic [31:0] HASH_C_LO = 32'h7F4A_7C15;
    localparam logic [31:0] HASH_C_HI = 32'h9E37_79B9;

    typedef enum logic [1:0] {
        MODE_POINT = 2'd0,
        MODE_POSE  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_KEPT = 3'd0,
        STAT_DUP  = 3'd1,
        STAT_CROP = 3'd2,
        STAT_OFF  = 3'd3,
        STAT_FULL = 3'd4,
        STAT_ACK  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CFG_FLAGS = 3'd0,
        CFG_SCALE = 3'd1,
        CFG_MIN_X = 3'd2,
        CFG_MIN_Y = 3'd3,
        CFG_MIN_Z = 3'd4,
        CFG_MAX_X = 3'd5,
        CFG_MAX_Y = 3'd6,
        CFG_MAX_Z = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_XF_MUL,
        S_XF_ACC,
        S_CROP,
        S_KEY_MUL,
        S_KEY_ACC,
        S_HASH_MUL,
        S_HASH_ACC,
        S_DIV_MUL,
        S_DIV_ACC,
        S_REM_MUL,
        S_REM_ACC,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_OUT
    } t_state;

endpackage

// File: hw/rtl/vdf_in_if.sv
interface vdf_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [3:0]        pose_index;
    logic signed [31:0] pose_value;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
    logic [31:0]       intensity_bits;
    logic              in_world_frame;

    modport source (
        output valid, mode, pose_index, pose_value, x_coord, y_coord, z_coord,
               intensity_bits, in_world_frame,
        input  ready
    );
    modport sink (
        input  valid, mode, pose_index, pose_value, x_coord, y_coord, z_coord,
               intensity_bits, in_world_frame,
        output ready
    );
endinterface

// File: hw/rtl/vdf_out_if.sv
interface vdf_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [31:0]        out_intensity;
    logic [12:0]        kept_count;

    modport source (
        output valid, status, world_x, world_y, world_z, out_intensity, kept_count,
        input  ready
    );
    modport sink (
        input  valid, status, world_x, world_y, world_z, out_intensity, kept_count,
        output ready
    );
endinterface

// File: hw/rtl/vdf_mul.sv
module vdf_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_prod
);
    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

// File: hw/rtl/vdf_table.sv
module vdf_table #(
    parameter int DEPTH = vdf_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH = 3 * vdf_pkg::KEY_AXIS_BITS_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    // entry: valid flag on top, key below
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/voxel_dedup_point_filter_core.sv
// voxel de-duplicating point filter
// input channel i_pt carries one beat per item: a point (mode point), a pose
// word load, a map clear or a no-op (mode none). output channel o_res returns
// exactly one beat per input beat, in order: status, world coordinates,
// intensity and kept count. configuration registers are written through
// i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. one item at a time:
// i_pt.ready is high only when the sequencer is idle. all multiplies go through
// one registered 33x33 signed multiplier: 9 for the pose transform, 3 for the
// voxel key, 3 for the hash and 2 for the slot reduction (reciprocal multiply,
// then quotient times depth and a compare-subtract). each hash probe is a
// registered memory read plus a check. a point in sensor frame passes transform,
// crop, key, hash, slot reduction and probes; one in world frame skips the
// transform; a cropped point goes on from the crop step, and disabled points and
// other items from idle, to the output step; the result is valid on the cycle
// after it is loaded. at reset and after each map clear the table is swept once,
// one slot per cycle, with i_pt.ready low (config writes still taken).
// when o_res is stalled the finished result waits in the output register and
// the sequencer holds until it drains.
module voxel_dedup_point_filter_core #(
    parameter int TABLE_DEPTH   = vdf_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_AXIS_BITS = vdf_pkg::KEY_AXIS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    vdf_in_if.sink      i_pt,
    vdf_out_if.source   o_res
);
    localparam int KW = 3 * KEY_AXIS_BITS;     // packed key width
    localparam int AW = $clog2(TABLE_DEPTH);   // slot index
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int FL = $clog2(TABLE_DEPTH + 1) - 1;   // floor(log2 depth)
    // reciprocal of the depth, rounded down, fits 32 unsigned bits
    localparam longint RECIP = ((64'sd1 <<< (32 + FL)) - 64'sd1) / TABLE_DEPTH;
    localparam longint KMAX = (64'sd1 <<< (KEY_AXIS_BITS - 1)) - 64'sd1;
    localparam longint KMIN = -(64'sd1 <<< (KEY_AXIS_BITS - 1));
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    // state and configuration
    vdf_pkg::t_state  r_state, n_state;
    logic [1:0]       r_flags;
    logic [25:0]      r_scale;
    logic signed [31:0] r_cmin [3];
    logic signed [31:0] r_cmax [3];
    logic signed [31:0] r_rot  [9];
    logic signed [31:0] r_trn  [3];
    logic [CW-1:0]    r_count;
    logic             r_clr_pend;
    logic [AW-1:0]    r_slot;
    logic             r_out_valid;

    // per-item working registers
    logic signed [31:0] r_p [3];
    logic signed [31:0] r_w [3];
    logic [31:0]      r_inten;
    logic [1:0]       r_row;
    logic [1:0]       r_col;
    logic [3:0]       r_pidx;
    logic signed [66:0] r_acc;
    logic [KW-1:0]    r_key;
    logic [31:0]      r_hash;
    logic [31:0]      r_quo;
    logic [CW-1:0]    r_probes;
    vdf_pkg::t_status r_status;

    // output register
    vdf_pkg::t_status r_o_status;
    logic signed [31:0] r_o_w [3];
    logic [31:0]      r_o_inten;
    logic [12:0]      r_o_count;

    // shared multiplier and table
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_prod;
    logic             tbl_we;
    logic [KW:0]      tbl_wdata, tbl_rdata;
    logic             in_fire, out_load;

    vdf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    vdf_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (KW + 1),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_addr  (r_slot),
        .i_wdata (tbl_wdata),
        .o_rdata (tbl_rdata)
    );

    // clamped voxel scale: zero acts as one LSB, above 1 mm voxels saturate
    logic [25:0] scale_c;
    always_comb begin
        if (r_scale == 26'd0) begin
            scale_c = 26'd1;
        end else if (r_scale > vdf_pkg::SCALE_MAX) begin
            scale_c = vdf_pkg::SCALE_MAX;
        end else begin
            scale_c = r_scale;
        end
    end

    logic [63:0] key64;
    assign key64 = 64'(r_key);

    // crop test on the world point
    logic outside;
    always_comb begin
        outside = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r_w[i] < r_cmin[i] || r_w[i] > r_cmax[i]) begin
                outside = 1'b1;
            end
        end
    end

    // transform row accumulate, floor and saturate
    logic signed [66:0] xf_sum, xf_sh;
    logic signed [31:0] xf_sat;
    always_comb begin
        xf_sum = r_acc + 67'(mul_prod);
        xf_sh  = (xf_sum >>> 16) + 67'(r_trn[r_row]);
        if (xf_sh > $signed(67'(SMAX))) begin
            xf_sat = 32'sh7FFF_FFFF;
        end else if (xf_sh < $signed(67'(SMIN))) begin
            xf_sat = 32'sh8000_0000;
        end else begin
            xf_sat = xf_sh[31:0];
        end
    end

    // voxel key per axis: floor(coord * scale / 2^32), saturated
    logic signed [65:0] key_sh;
    logic [KEY_AXIS_BITS-1:0] key_ax;
    always_comb begin
        key_sh = mul_prod >>> 32;
        if (key_sh > $signed(66'(KMAX))) begin
            key_ax = KEY_AXIS_BITS'(KMAX);
        end else if (key_sh < $signed(66'(KMIN))) begin
            key_ax = KEY_AXIS_BITS'(KMIN);
        end else begin
            key_ax = key_sh[KEY_AXIS_BITS-1:0];
        end
    end

    // slot remainder: the estimated quotient is at most one short
    logic [31:0] rem_est, rem_fix;
    always_comb begin
        rem_est = r_hash - mul_prod[31:0];
        rem_fix = (rem_est >= 32'(TABLE_DEPTH)) ? rem_est - 32'(TABLE_DEPTH) : rem_est;
    end

    logic [AW:0] slot_inc;
    assign slot_inc = {1'b0, r_slot} + 1'b1;

    logic rd_valid, rd_match;
    assign rd_valid = tbl_rdata[KW];
    assign rd_match = tbl_rdata[KW-1:0] == r_key;

    // sequencer: next state and datapath controls
    always_comb begin
        n_state   = r_state;
        mul_a     = '0;
        mul_b     = '0;
        tbl_we    = 1'b0;
        tbl_wdata = '0;
        out_load  = 1'b0;
        unique case (r_state)
            vdf_pkg::S_CLEAR: begin
                tbl_we = 1'b1;
                if (r_slot == AW'(TABLE_DEPTH - 1)) begin
                    n_state = vdf_pkg::S_IDLE;
                end
            end
            vdf_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_pt.mode != vdf_pkg::MODE_POINT || !r_flags[0]) begin
                        n_state = vdf_pkg::S_OUT;
                    end else if (i_pt.in_world_frame) begin
                        n_state = vdf_pkg::S_CROP;
                    end else begin
                        n_state = vdf_pkg::S_XF_MUL;
                    end
                end
            end
            vdf_pkg::S_XF_MUL: begin
                mul_a   = 33'(r_rot[r_pidx]);
                mul_b   = 33'(r_p[r_col]);
                n_state = vdf_pkg::S_XF_ACC;
            end
            vdf_pkg::S_XF_ACC: begin
                n_state = (r_pidx == 4'd8) ? vdf_pkg::S_CROP : vdf_pkg::S_XF_MUL;
            end
            vdf_pkg::S_CROP: begin
                n_state = (r_flags[1] && outside) ? vdf_pkg::S_OUT : vdf_pkg::S_KEY_MUL;
            end
            vdf_pkg::S_KEY_MUL: begin
                mul_a   = 33'(r_w[r_row]);
                mul_b   = $signed({7'd0, scale_c});
                n_state = vdf_pkg::S_KEY_ACC;
            end
            vdf_pkg::S_KEY_ACC: begin
                n_state = (r_row == 2'd2) ? vdf_pkg::S_HASH_MUL : vdf_pkg::S_KEY_MUL;
            end
            vdf_pkg::S_HASH_MUL: begin
                // low 64 bits of key * C need only three partial products
                case (r_row)
                    2'd0: begin
                        mul_a = $signed({1'b0, key64[31:0]});
                        mul_b = $signed({1'b0, vdf_pkg::HASH_C_LO});
                    end
                    2'd1: begin
                        mul_a = $signed({1'b0, key64[31:0]});
                        mul_b = $signed({1'b0, vdf_pkg::HASH_C_HI});
                    end
                    default: begin
                        mul_a = $signed({1'b0, key64[63:32]});
                        mul_b = $signed({1'b0, vdf_pkg::HASH_C_LO});
                    end
                endcase
                n_state = vdf_pkg::S_HASH_ACC;
            end
            vdf_pkg::S_HASH_ACC: begin
                n_state = (r_row == 2'd2) ? vdf_pkg::S_DIV_MUL : vdf_pkg::S_HASH_MUL;
            end
            vdf_pkg::S_DIV_MUL: begin
                // quotient estimate: hash times the rounded-down reciprocal
                mul_a   = $signed({1'b0, r_hash});
                mul_b   = $signed({1'b0, 32'(RECIP)});
                n_state = vdf_pkg::S_DIV_ACC;
            end
            vdf_pkg::S_DIV_ACC: begin
                n_state = vdf_pkg::S_REM_MUL;
            end
            vdf_pkg::S_REM_MUL: begin
                mul_a   = $signed({1'b0, r_quo});
                mul_b   = 33'(TABLE_DEPTH);
                n_state = vdf_pkg::S_REM_ACC;
            end
            vdf_pkg::S_REM_ACC: begin
                n_state = vdf_pkg::S_PROBE_RD;
            end
            vdf_pkg::S_PROBE_RD: begin
                n_state = vdf_pkg::S_PROBE_CHK;
            end
            vdf_pkg::S_PROBE_CHK: begin
                if (!rd_valid) begin
                    tbl_we    = 1'b1;
                    tbl_wdata = {1'b1, r_key};
                    n_state   = vdf_pkg::S_OUT;
                end else if (rd_match || r_probes == CW'(TABLE_DEPTH - 1)) begin
                    n_state = vdf_pkg::S_OUT;
                end else begin
                    n_state = vdf_pkg::S_PROBE_RD;
                end
            end
            vdf_pkg::S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = r_clr_pend ? vdf_pkg::S_CLEAR : vdf_pkg::S_IDLE;
                end
            end
            default: n_state = vdf_pkg::S_CLEAR;
        endcase
    end

    assign i_pt.ready = (r_state == vdf_pkg::S_IDLE);
    assign in_fire    = i_pt.valid && i_pt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdf_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control state: configuration, pose, count, table pointer, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= 2'd1;
            r_scale     <= 26'(vdf_pkg::ONE_Q16);
            for (int i = 0; i < 3; i++) begin
                r_cmin[i] <= 32'sh8000_0000;
                r_cmax[i] <= 32'sh7FFF_FFFF;
                r_trn[i]  <= '0;
            end
            for (int i = 0; i < 9; i++) begin
                r_rot[i] <= (i == 0 || i == 4 || i == 8) ? vdf_pkg::ONE_Q16 : '0;
            end
            r_count     <= '0;
            r_clr_pend  <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (vdf_pkg::t_cfg_idx'(i_cfg_idx))
                    vdf_pkg::CFG_FLAGS: r_flags   <= i_cfg_data[1:0];
                    vdf_pkg::CFG_SCALE: r_scale   <= i_cfg_data[25:0];
                    vdf_pkg::CFG_MIN_X: r_cmin[0] <= i_cfg_data;
                    vdf_pkg::CFG_MIN_Y: r_cmin[1] <= i_cfg_data;
                    vdf_pkg::CFG_MIN_Z: r_cmin[2] <= i_cfg_data;
                    vdf_pkg::CFG_MAX_X: r_cmax[0] <= i_cfg_data;
                    vdf_pkg::CFG_MAX_Y: r_cmax[1] <= i_cfg_data;
                    vdf_pkg::CFG_MAX_Z: r_cmax[2] <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_fire && i_pt.mode == vdf_pkg::MODE_POSE) begin
                if (i_pt.pose_index < 4'd9) begin
                    r_rot[i_pt.pose_index] <= i_pt.pose_value;
                end else if (i_pt.pose_index < 4'd12) begin
                    r_trn[2'(i_pt.pose_index - 4'd9)] <= i_pt.pose_value;
                end
            end
            if (in_fire && i_pt.mode == vdf_pkg::MODE_CLEAR) begin
                r_count    <= '0;
                r_clr_pend <= 1'b1;
            end

            // table pointer: sweep, probe start and linear step
            if (r_state == vdf_pkg::S_CLEAR) begin
                if (r_slot == AW'(TABLE_DEPTH - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end else if (r_state == vdf_pkg::S_REM_ACC) begin
                r_slot <= rem_fix[AW-1:0];
            end else if (r_state == vdf_pkg::S_PROBE_CHK && rd_valid) begin
                r_slot <= (slot_inc == (AW + 1)'(TABLE_DEPTH)) ? '0 : slot_inc[AW-1:0];
            end else if (out_load) begin
                r_slot <= '0;
            end

            if (r_state == vdf_pkg::S_PROBE_CHK && !rd_valid) begin
                r_count <= r_count + 1'b1;
            end
            if (out_load) begin
                r_clr_pend <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-item datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            vdf_pkg::S_IDLE: begin
                r_p[0]   <= i_pt.x_coord;
                r_p[1]   <= i_pt.y_coord;
                r_p[2]   <= i_pt.z_coord;
                r_row    <= '0;
                r_col    <= '0;
                r_pidx   <= '0;
                r_acc    <= '0;
                if (i_pt.mode == vdf_pkg::MODE_POINT && r_flags[0]) begin
                    r_w[0]   <= i_pt.x_coord;
                    r_w[1]   <= i_pt.y_coord;
                    r_w[2]   <= i_pt.z_coord;
                    r_inten  <= i_pt.intensity_bits;
                    r_status <= vdf_pkg::STAT_ACK;
                end else begin
                    // acknowledgements and disabled points carry zeros
                    for (int i = 0; i < 3; i++) begin
                        r_w[i] <= '0;
                    end
                    r_inten  <= '0;
                    r_status <= (i_pt.mode == vdf_pkg::MODE_POINT) ? vdf_pkg::STAT_OFF
                                                                   : vdf_pkg::STAT_ACK;
                end
            end
            vdf_pkg::S_XF_ACC: begin
                r_pidx <= r_pidx + 1'b1;
                if (r_col == 2'd2) begin
                    r_w[r_row] <= xf_sat;
                    r_acc      <= '0;
                    r_col      <= '0;
                    r_row      <= r_row + 1'b1;
                end else begin
                    r_acc <= xf_sum;
                    r_col <= r_col + 1'b1;
                end
            end
            vdf_pkg::S_CROP: begin
                r_row    <= '0;
                r_status <= vdf_pkg::STAT_CROP;
            end
            vdf_pkg::S_KEY_ACC: begin
                r_key[r_row * KEY_AXIS_BITS +: KEY_AXIS_BITS] <= key_ax;
                r_row <= (r_row == 2'd2) ? 2'd0 : r_row + 1'b1;
            end
            vdf_pkg::S_HASH_ACC: begin
                r_hash <= (r_row == 2'd0) ? mul_prod[63:32] : r_hash + mul_prod[31:0];
                r_row  <= r_row + 1'b1;
            end
            vdf_pkg::S_DIV_ACC: begin
                r_quo <= 32'(mul_prod >>> (32 + FL));
            end
            vdf_pkg::S_REM_ACC: begin
                r_probes <= '0;
            end
            vdf_pkg::S_PROBE_CHK: begin
                r_probes <= r_probes + 1'b1;
                if (!rd_valid) begin
                    r_status <= vdf_pkg::STAT_KEPT;
                end else if (rd_match) begin
                    r_status <= vdf_pkg::STAT_DUP;
                end else begin
                    r_status <= vdf_pkg::STAT_FULL;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_o_status <= r_status;
            for (int i = 0; i < 3; i++) begin
                r_o_w[i] <= r_w[i];
            end
            r_o_inten <= r_inten;
            r_o_count <= 13'(r_count);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_o_status;
    assign o_res.world_x       = r_o_w[0];
    assign o_res.world_y       = r_o_w[1];
    assign o_res.world_z       = r_o_w[2];
    assign o_res.out_intensity = r_o_inten;
    assign o_res.kept_count    = r_o_count;

    // the kept count never exceeds the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("kept count above table depth");

    // a slot claimed on an empty probe bumps the count by one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vdf_pkg::S_PROBE_CHK && !rd_valid)
        |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("insert did not bump kept count");

    // a result appears only from the output step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == vdf_pkg::S_OUT))
        else $error("result loaded outside output step");

    // probe run stays below the table size
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vdf_pkg::S_PROBE_CHK) |-> r_probes < CW'(TABLE_DEPTH))
        else $error("probe count overrun");
endmodule
